[sv/cvsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cvsb_pkg;

  // field widths
  localparam int RAW_W    = 16;
  localparam int OFF_W    = 12;
  localparam int LRES_W   = 8;
  localparam int CUR_W    = 21;
  localparam int TEMP_W   = 12;
  localparam int VOLT_W   = 16;
  localparam int TOTAL_W  = 21;
  localparam int CNT_W    = 5;
  localparam int MASK_W   = 25;
  localparam int SPREAD_W = 17;
  localparam int TICK_W   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int CHANNELS_DEF = 25;
  localparam int STORE_DEPTH  = 25;
  localparam int JUMP_HOLD    = 5;

  localparam logic [VOLT_W-1:0] MIN_START = 16'd50000;
  localparam int SPREAD_LIMIT = 1000;
  localparam int JUMP_DELTA   = 200;
  localparam int ROUND_ADD    = 500;

  // current compensation: /10 then /1000 by reciprocal multiply plus one fix-up step
  localparam int PROD_W  = CUR_W + LRES_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int REC10_W = 22;
  localparam logic [REC10_W-1:0] REC10 = 22'd3355443;
  localparam int REC10_SH = 25;
  localparam int M1_W     = MAG_W + REC10_W;
  localparam int Q1_W     = M1_W - REC10_SH;
  localparam int Y_W      = Q1_W + 2;
  localparam int YMAG_W   = Q1_W;
  localparam int REC1K_W  = 25;
  localparam logic [REC1K_W-1:0] REC1K = 25'd17179869;
  localparam int REC1K_SH = 34;
  localparam int M2_W     = YMAG_W + REC1K_W;
  localparam int Q2_W     = M2_W - REC1K_SH;
  localparam int SUM_W    = RAW_W + 3;

  // reset values of the registers
  localparam logic [MASK_W-1:0] USED_MASK_RST  = 25'd1048575;
  localparam logic [CNT_W-1:0]  CELL_COUNT_RST = 5'd20;
  localparam logic [15:0]       OPEN_RST       = 16'd50;
  localparam logic [15:0]       CLOSE_RST      = 16'd20;
  localparam logic [15:0]       MIN_VOLT_RST   = 16'd3050;
  localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = 12'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USED_MASK  = 3'd0,
    REG_CELL_COUNT = 3'd1,
    REG_OPEN       = 3'd2,
    REG_CLOSE      = 3'd3,
    REG_MIN_VOLT   = 3'd4,
    REG_TEMP_LIMIT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [MASK_W-1:0] used_cell_mask;
    logic [CNT_W-1:0]  cell_count;
    logic [15:0]       balance_open_spread;
    logic [15:0]       balance_close_spread;
    logic [15:0]       balance_min_volt;
    logic [TEMP_W-1:0] balance_temp_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAG,
    S_FIX,
    S_MUL2,
    S_VOLT,
    S_ACC,
    S_DLOAD,
    S_DIV,
    S_CMP_RD,
    S_CMP_EV,
    S_MAP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mag;
    logic fix;
    logic mul2;
    logic volt;
    logic acc;
    logic dload;
    logic div_step;
    logic cmp_rd;
    logic cmp_ev;
    logic map_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/cvsb_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cvsb_in_if;
  logic                                valid;
  logic                                ready;
  logic [cvsb_pkg::RAW_W-1:0]          raw_volt;
  logic signed [cvsb_pkg::OFF_W-1:0]   cal_offset;
  logic signed [cvsb_pkg::LRES_W-1:0]  line_res;
  logic signed [cvsb_pkg::CUR_W-1:0]   pack_current;
  logic                                charging;
  logic signed [cvsb_pkg::TEMP_W-1:0]  temp_max;
  logic                                last_channel;

  modport source (
    output valid, raw_volt, cal_offset, line_res, pack_current, charging, temp_max,
           last_channel,
    input  ready
  );
  modport sink (
    input  valid, raw_volt, cal_offset, line_res, pack_current, charging, temp_max,
           last_channel,
    output ready
  );
endinterface

interface cvsb_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [cvsb_pkg::VOLT_W-1:0]           cell_volt;
  logic                                  cell_used;
  logic                                  scan_done;
  logic [cvsb_pkg::TOTAL_W-1:0]          volt_total;
  logic [cvsb_pkg::VOLT_W-1:0]           volt_max;
  logic [cvsb_pkg::VOLT_W-1:0]           volt_min;
  logic signed [cvsb_pkg::SPREAD_W-1:0]  volt_spread;
  logic [cvsb_pkg::TOTAL_W-1:0]          volt_avg;
  logic [cvsb_pkg::CNT_W-1:0]            max_channel;
  logic [cvsb_pkg::MASK_W-1:0]           balance_mask;
  logic                                  balance_enable;
  logic                                  jump_flag;

  modport source (
    output valid, cell_volt, cell_used, scan_done, volt_total, volt_max, volt_min,
           volt_spread, volt_avg, max_channel, balance_mask, balance_enable, jump_flag,
    input  ready
  );
  modport sink (
    input  valid, cell_volt, cell_used, scan_done, volt_total, volt_max, volt_min,
           volt_spread, volt_avg, max_channel, balance_mask, balance_enable, jump_flag,
    output ready
  );
endinterface

`default_nettype wire

[sv/cvsb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cvsb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output cvsb_pkg::cmd_t     cmd,
  input  cvsb_pkg::sts_t     sts
);

  cvsb_pkg::state_t state;
  cvsb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cvsb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      cvsb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = cvsb_pkg::S_MAG;
        end
      end
      cvsb_pkg::S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = cvsb_pkg::S_FIX;
      end
      cvsb_pkg::S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = cvsb_pkg::S_MUL2;
      end
      cvsb_pkg::S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = cvsb_pkg::S_VOLT;
      end
      cvsb_pkg::S_VOLT: begin
        cmd.volt   = 1'b1;
        state_next = cvsb_pkg::S_ACC;
      end
      cvsb_pkg::S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? cvsb_pkg::S_DLOAD : cvsb_pkg::S_OUT;
      end
      cvsb_pkg::S_DLOAD: begin
        cmd.dload  = 1'b1;
        state_next = cvsb_pkg::S_DIV;
      end
      cvsb_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = cvsb_pkg::S_CMP_RD;
        end
      end
      cvsb_pkg::S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_next = cvsb_pkg::S_CMP_EV;
      end
      cvsb_pkg::S_CMP_EV: begin
        cmd.cmp_ev = 1'b1;
        state_next = sts.sweep_last ? cvsb_pkg::S_MAP : cvsb_pkg::S_CMP_RD;
      end
      cvsb_pkg::S_MAP: begin
        cmd.map_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = cvsb_pkg::S_OUT;
        end
      end
      cvsb_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = cvsb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cvsb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/cvsb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module cvsb_dp #(
  parameter int CHANNELS = cvsb_pkg::CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  cvsb_pkg::cmd_t                          cmd,
  output cvsb_pkg::sts_t                          sts,
  input  cvsb_pkg::cfg_t                          cfg,
  input  wire logic [cvsb_pkg::RAW_W-1:0]         raw_volt,
  input  wire logic signed [cvsb_pkg::OFF_W-1:0]  cal_offset,
  input  wire logic signed [cvsb_pkg::LRES_W-1:0] line_res,
  input  wire logic signed [cvsb_pkg::CUR_W-1:0]  pack_current,
  input  wire logic                               charging,
  input  wire logic signed [cvsb_pkg::TEMP_W-1:0] temp_max,
  input  wire logic                               last_channel,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [cvsb_pkg::VOLT_W-1:0]             cell_volt,
  output logic                                    cell_used,
  output logic                                    scan_done,
  output logic [cvsb_pkg::TOTAL_W-1:0]            volt_total,
  output logic [cvsb_pkg::VOLT_W-1:0]             volt_max,
  output logic [cvsb_pkg::VOLT_W-1:0]             volt_min,
  output logic signed [cvsb_pkg::SPREAD_W-1:0]    volt_spread,
  output logic [cvsb_pkg::TOTAL_W-1:0]            volt_avg,
  output logic [cvsb_pkg::CNT_W-1:0]              max_channel,
  output logic [cvsb_pkg::MASK_W-1:0]             balance_mask,
  output logic                                    balance_enable,
  output logic                                    jump_flag
);

  localparam int STORE_N = (CHANNELS < cvsb_pkg::STORE_DEPTH) ? CHANNELS
                                                                : cvsb_pkg::STORE_DEPTH;
  localparam int AW = (STORE_N > 1) ? $clog2(STORE_N) : 1;

  localparam int VW = cvsb_pkg::VOLT_W;
  localparam int TW = cvsb_pkg::TOTAL_W;
  localparam int CW = cvsb_pkg::CNT_W;
  localparam int MW = cvsb_pkg::MASK_W;

  // latched channel
  logic [VW-1:0]                          raw_r;
  logic signed [cvsb_pkg::OFF_W-1:0]      off_r;
  logic signed [cvsb_pkg::PROD_W-1:0]     prod_r;
  logic                                   charging_r;
  logic signed [cvsb_pkg::TEMP_W-1:0]     tmax_r;
  logic                                   last_r;
  logic                                   used_r;
  logic [CW-1:0]                          chan_r;

  // calibration pipeline
  logic [cvsb_pkg::MAG_W-1:0]   mag_r;
  logic                         psign_r;
  logic [cvsb_pkg::M1_W-1:0]    m1_r;
  logic [cvsb_pkg::YMAG_W-1:0]  ymag_r;
  logic                         ysign_r;
  logic [cvsb_pkg::M2_W-1:0]    m2_r;
  logic [VW-1:0]                volt_r;

  // scan state
  logic [CW-1:0]                chan_idx;
  logic [CW-1:0]                used_seen;
  logic [TW-1:0]                run_total;
  logic [VW-1:0]                run_max;
  logic [VW-1:0]                run_min;
  logic [CW-1:0]                run_max_ch;
  logic                         balance_allowed;
  logic [VW-1:0]                ref_max;
  logic [VW-1:0]                ref_min;
  logic [cvsb_pkg::TICK_W-1:0]  jump_ticks;

  // end of scan
  logic [CW-1:0]                step_cnt;
  logic [TW-1:0]                dq;
  logic [CW-1:0]                drem;
  logic signed [cvsb_pkg::SPREAD_W-1:0] spread_r;
  logic [VW-1:0]                aspread_r;
  logic                         jump_r;
  logic [MW-1:0]                rank_mask;
  logic                         more;
  logic [CW-1:0]                rank_ptr;
  logic [MW-1:0]                phys_mask;

  logic [VW-1:0]                store [STORE_N];
  logic [VW-1:0]                rd_data;

  // combinational
  logic [MW-1:0]                mask_sh;
  logic                         used_now;
  logic [cvsb_pkg::MAG_W-1:0]   mag_now;
  logic [cvsb_pkg::PROD_W-1:0]  prod_neg;
  logic [cvsb_pkg::Q1_W-1:0]    q0;
  logic [cvsb_pkg::PROD_W-1:0]  q0x10;
  logic [cvsb_pkg::PROD_W-1:0]  r1;
  logic [cvsb_pkg::Q1_W-1:0]    q1;
  logic signed [cvsb_pkg::Y_W-1:0] sq1;
  logic signed [cvsb_pkg::Y_W-1:0] y;
  logic [cvsb_pkg::Y_W-1:0]     y_neg;
  logic [cvsb_pkg::Q2_W-1:0]    q0b;
  logic [cvsb_pkg::YMAG_W:0]    q0bx1k;
  logic [cvsb_pkg::YMAG_W:0]    r2;
  logic [cvsb_pkg::Q2_W-1:0]    q2;
  logic signed [cvsb_pkg::Q2_W:0]  comp;
  logic signed [cvsb_pkg::SUM_W-1:0] vsum;
  logic [VW-1:0]                vsat;
  logic [CW-1:0]                divisor;
  logic [CW:0]                  dshift;
  logic signed [cvsb_pkg::SPREAD_W-1:0] spread_now;
  logic [cvsb_pkg::SPREAD_W-1:0] spread_neg;
  logic signed [cvsb_pkg::SPREAD_W-1:0] dmax;
  logic signed [cvsb_pkg::SPREAD_W-1:0] dmin;
  logic [cvsb_pkg::SPREAD_W-1:0] dmax_abs;
  logic [cvsb_pkg::SPREAD_W-1:0] dmin_abs;
  logic                         rank_hit;
  logic                         allowed_next;
  logic                         enable_now;

  assign mask_sh  = cfg.used_cell_mask >> chan_idx;
  assign used_now = (chan_idx < CW'(STORE_N)) && mask_sh[0];

  assign prod_neg = -prod_r;
  assign mag_now  = prod_r[cvsb_pkg::PROD_W-1] ? prod_neg[cvsb_pkg::MAG_W-1:0]
                                                : prod_r[cvsb_pkg::MAG_W-1:0];

  // trunc(|prod| / 10), then signed + 500
  assign q0    = m1_r[cvsb_pkg::M1_W-1:cvsb_pkg::REC10_SH];
  assign q0x10 = ({4'b0, q0} << 3) + ({4'b0, q0} << 1);
  assign r1    = {1'b0, mag_r} - q0x10;
  assign q1    = q0 + cvsb_pkg::Q1_W'(r1 >= cvsb_pkg::PROD_W'(10));
  assign sq1   = psign_r ? -$signed({2'b00, q1}) : $signed({2'b00, q1});
  assign y     = sq1 + cvsb_pkg::Y_W'(cvsb_pkg::ROUND_ADD);
  assign y_neg = -y;

  // trunc(y / 1000)
  assign q0b    = m2_r[cvsb_pkg::M2_W-1:cvsb_pkg::REC1K_SH];
  assign q0bx1k = (cvsb_pkg::YMAG_W + 1)'(q0b) * (cvsb_pkg::YMAG_W + 1)'(1000);
  assign r2     = {1'b0, ymag_r} - q0bx1k;
  assign q2     = q0b + cvsb_pkg::Q2_W'(r2 >= (cvsb_pkg::YMAG_W + 1)'(1000));
  assign comp   = ysign_r ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
  assign vsum   = $signed({3'b000, raw_r})
                + $signed({{2{comp[cvsb_pkg::Q2_W]}}, comp})
                + $signed({{7{off_r[cvsb_pkg::OFF_W-1]}}, off_r});

  always_comb begin
    if (vsum[cvsb_pkg::SUM_W-1]) begin
      vsat = '0;
    end else if (vsum[cvsb_pkg::SUM_W-2:VW] != '0) begin
      vsat = '1;
    end else begin
      vsat = vsum[VW-1:0];
    end
  end

  // average divider, one quotient bit per step
  assign divisor = (cfg.cell_count == '0) ? CW'(1) : cfg.cell_count;
  assign dshift  = {drem, dq[TW-1]};

  assign spread_now = $signed({1'b0, run_max}) - $signed({1'b0, run_min});
  assign spread_neg = -spread_now;
  assign dmax       = $signed({1'b0, ref_max}) - $signed({1'b0, run_max});
  assign dmin       = $signed({1'b0, ref_min}) - $signed({1'b0, run_min});
  assign dmax_abs   = dmax[cvsb_pkg::SPREAD_W-1] ? -dmax : dmax;
  assign dmin_abs   = dmin[cvsb_pkg::SPREAD_W-1] ? -dmin : dmin;

  assign rank_hit = (step_cnt < cfg.cell_count) && (step_cnt < CW'(STORE_N))
                 && (rd_data > cfg.balance_min_volt) && ({5'b0, rd_data} > dq);

  always_comb begin
    allowed_next = balance_allowed;
    if (aspread_r >= cfg.balance_open_spread) begin
      allowed_next = 1'b1;
    end else if (aspread_r < cfg.balance_close_spread) begin
      allowed_next = 1'b0;
    end
    if (aspread_r >= VW'(cvsb_pkg::SPREAD_LIMIT)) begin
      allowed_next = 1'b0;
    end
  end

  assign enable_now = charging_r && (tmax_r < $signed(cfg.balance_temp_limit)) && more
                   && allowed_next;

  assign sts.last       = last_r;
  assign sts.div_last   = (step_cnt == CW'(TW - 1));
  assign sts.sweep_last = (step_cnt == CW'(cvsb_pkg::STORE_DEPTH - 1));
  assign sts.out_free   = !out_valid || out_ready;

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r      <= raw_volt;
      off_r      <= cal_offset;
      prod_r     <= cvsb_pkg::PROD_W'(pack_current) * cvsb_pkg::PROD_W'(line_res);
      charging_r <= charging;
      tmax_r     <= temp_max;
      last_r     <= last_channel;
      used_r     <= used_now;
      chan_r     <= chan_idx;
    end
    if (cmd.mag) begin
      mag_r   <= mag_now;
      psign_r <= prod_r[cvsb_pkg::PROD_W-1];
      m1_r    <= cvsb_pkg::M1_W'(mag_now) * cvsb_pkg::M1_W'(cvsb_pkg::REC10);
    end
    if (cmd.fix) begin
      ysign_r <= y[cvsb_pkg::Y_W-1];
      ymag_r  <= y[cvsb_pkg::Y_W-1] ? y_neg[cvsb_pkg::YMAG_W-1:0]
                                    : y[cvsb_pkg::YMAG_W-1:0];
    end
    if (cmd.mul2) begin
      m2_r <= cvsb_pkg::M2_W'(ymag_r) * cvsb_pkg::M2_W'(cvsb_pkg::REC1K);
    end
    if (cmd.volt) begin
      volt_r <= used_r ? vsat : '0;
    end
    if (cmd.dload) begin
      dq   <= run_total;
      drem <= '0;
    end
    if (cmd.div_step) begin
      if (dshift >= {1'b0, divisor}) begin
        drem <= CW'(dshift - {1'b0, divisor});
        dq   <= {dq[TW-2:0], 1'b1};
      end else begin
        drem <= dshift[CW-1:0];
        dq   <= {dq[TW-2:0], 1'b0};
      end
      spread_r  <= spread_now;
      aspread_r <= spread_now[cvsb_pkg::SPREAD_W-1] ? spread_neg[VW-1:0]
                                                    : spread_now[VW-1:0];
      jump_r    <= (dmax_abs > cvsb_pkg::SPREAD_W'(cvsb_pkg::JUMP_DELTA))
                || (dmin_abs > cvsb_pkg::SPREAD_W'(cvsb_pkg::JUMP_DELTA));
    end
    if (cmd.dload) begin
      rank_mask <= '0;
      more      <= 1'b0;
      rank_ptr  <= '0;
      phys_mask <= '0;
    end
    if (cmd.cmp_ev) begin
      rank_mask[step_cnt] <= rank_hit;
      if (rank_hit) begin
        more <= 1'b1;
      end
    end
    if (cmd.map_step && cfg.used_cell_mask[step_cnt]) begin
      if (rank_ptr < CW'(MW) && rank_mask[rank_ptr]) begin
        phys_mask[step_cnt] <= 1'b1;
      end
      rank_ptr <= rank_ptr + CW'(1);
    end
    if (cmd.out_load) begin
      cell_volt      <= volt_r;
      cell_used      <= used_r;
      scan_done      <= last_r;
      volt_total     <= last_r ? run_total : '0;
      volt_max       <= last_r ? run_max : '0;
      volt_min       <= last_r ? run_min : '0;
      volt_spread    <= last_r ? spread_r : '0;
      volt_avg       <= last_r ? dq : '0;
      max_channel    <= last_r ? run_max_ch : '0;
      balance_mask   <= (last_r && enable_now) ? phys_mask : '0;
      balance_enable <= last_r && enable_now;
      jump_flag      <= last_r && jump_r;
    end
  end

  // cell store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.acc && used_r) begin
      store[used_seen[AW-1:0]] <= volt_r;
    end
    if (cmd.cmp_rd) begin
      rd_data <= store[step_cnt[AW-1:0]];
    end
  end

  // control and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      step_cnt        <= '0;
      chan_idx        <= '0;
      used_seen       <= '0;
      run_total       <= '0;
      run_max         <= '0;
      run_min         <= cvsb_pkg::MIN_START;
      run_max_ch      <= '0;
      balance_allowed <= 1'b0;
      ref_max         <= '0;
      ref_min         <= '0;
      jump_ticks      <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.dload) begin
        step_cnt <= '0;
      end else if (cmd.div_step) begin
        step_cnt <= sts.div_last ? '0 : step_cnt + CW'(1);
      end else if (cmd.cmp_ev || cmd.map_step) begin
        step_cnt <= sts.sweep_last ? '0 : step_cnt + CW'(1);
      end

      if (cmd.acc) begin
        if (chan_idx != '1) begin
          chan_idx <= chan_idx + CW'(1);
        end
        if (used_r) begin
          used_seen <= used_seen + CW'(1);
          run_total <= run_total + TW'(volt_r);
          if (run_max < volt_r) begin
            run_max    <= volt_r;
            run_max_ch <= chan_r;
          end
          if (volt_r < run_min) begin
            run_min <= volt_r;
          end
        end
      end

      if (cmd.out_load && last_r) begin
        balance_allowed <= allowed_next;
        if (jump_r) begin
          if (jump_ticks < cvsb_pkg::TICK_W'(cvsb_pkg::JUMP_HOLD)) begin
            jump_ticks <= jump_ticks + cvsb_pkg::TICK_W'(1);
          end else begin
            ref_max    <= run_max;
            ref_min    <= run_min;
            jump_ticks <= '0;
          end
        end else begin
          jump_ticks <= '0;
          ref_max    <= run_max;
          ref_min    <= run_min;
        end
        chan_idx  <= '0;
        used_seen <= '0;
        run_total <= '0;
        run_max   <= '0;
        run_min   <= cvsb_pkg::MIN_START;
      end
    end
  end

endmodule

`default_nettype wire

[sv/cell_voltage_scan_balance_decision.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cell scan and passive balancing decision.
// in_ch takes one beat per physical channel of a scan, in channel order; the beat
// with last_channel set closes the scan. out_ch gives one beat per input beat: the
// calibrated voltage of that channel, and on the closing beat also the scan summary,
// the balance mask and enable and the jump flag (all zero on other beats).
// cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle.
// A channel beat runs the magnitude, fix-up, multiply, voltage and accumulate steps
// before it loads into out_ch; a new beat is taken only after that load. The closing
// beat adds 21 divider iterations for the average, a sweep that reads and evaluates
// each rank over the store's single read port, and a 25-step rank-to-channel map.
// One channel is in flight at a time; in_ch.ready is high while the block waits
// for a beat, also while a finished beat still sits in the output register.
// If out_ch stalls, the finished beat holds and the next one waits in the block.
// Reset (synchronous) restores register defaults, clears the running scan and the
// hysteresis and jump state; the cell store keeps whatever it held.
module cell_voltage_scan_balance_decision #(
  parameter int CHANNELS = cvsb_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  cvsb_in_if.sink                                  in_ch,
  cvsb_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [cvsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cvsb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cvsb_pkg::cfg_t cfg;
  cvsb_pkg::cmd_t cmd;
  cvsb_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.used_cell_mask       <= cvsb_pkg::USED_MASK_RST;
      cfg.cell_count           <= cvsb_pkg::CELL_COUNT_RST;
      cfg.balance_open_spread  <= cvsb_pkg::OPEN_RST;
      cfg.balance_close_spread <= cvsb_pkg::CLOSE_RST;
      cfg.balance_min_volt     <= cvsb_pkg::MIN_VOLT_RST;
      cfg.balance_temp_limit   <= cvsb_pkg::TEMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cvsb_pkg::REG_USED_MASK:  cfg.used_cell_mask       <= cfg_data;
        cvsb_pkg::REG_CELL_COUNT: cfg.cell_count           <= cfg_data[cvsb_pkg::CNT_W-1:0];
        cvsb_pkg::REG_OPEN:       cfg.balance_open_spread  <= cfg_data[15:0];
        cvsb_pkg::REG_CLOSE:      cfg.balance_close_spread <= cfg_data[15:0];
        cvsb_pkg::REG_MIN_VOLT:   cfg.balance_min_volt     <= cfg_data[15:0];
        cvsb_pkg::REG_TEMP_LIMIT: cfg.balance_temp_limit   <= cfg_data[cvsb_pkg::TEMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cvsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cvsb_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .raw_volt       (in_ch.raw_volt),
    .cal_offset     (in_ch.cal_offset),
    .line_res       (in_ch.line_res),
    .pack_current   (in_ch.pack_current),
    .charging       (in_ch.charging),
    .temp_max       (in_ch.temp_max),
    .last_channel   (in_ch.last_channel),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .cell_volt      (out_ch.cell_volt),
    .cell_used      (out_ch.cell_used),
    .scan_done      (out_ch.scan_done),
    .volt_total     (out_ch.volt_total),
    .volt_max       (out_ch.volt_max),
    .volt_min       (out_ch.volt_min),
    .volt_spread    (out_ch.volt_spread),
    .volt_avg       (out_ch.volt_avg),
    .max_channel    (out_ch.max_channel),
    .balance_mask   (out_ch.balance_mask),
    .balance_enable (out_ch.balance_enable),
    .jump_flag      (out_ch.jump_flag)
  );

endmodule

`default_nettype wire

[sv/cvsb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module cvsb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [cvsb_pkg::VOLT_W-1:0]       cell_volt,
  input wire logic                              cell_used,
  input wire logic                              scan_done,
  input wire logic [cvsb_pkg::TOTAL_W-1:0]      volt_total,
  input wire logic [cvsb_pkg::MASK_W-1:0]       balance_mask,
  input wire logic                              balance_enable,
  input wire logic                              jump_flag
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_volt))
    else $error("result beat changed while stalled");

  // one channel in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a channel is in flight");

  a_mask_gated: assert property (@(posedge clk) disable iff (rst)
    out_valid && !balance_enable |-> balance_mask == '0)
    else $error("balance mask set while balancing disabled");

  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !scan_done |-> volt_total == '0 && !balance_enable && !jump_flag)
    else $error("summary fields set on a mid-scan beat");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_used |-> cell_volt == '0)
    else $error("voltage reported on an unused channel");

endmodule

bind cell_voltage_scan_balance_decision cvsb_checker u_cvsb_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cell_volt      (out_ch.cell_volt),
  .cell_used      (out_ch.cell_used),
  .scan_done      (out_ch.scan_done),
  .volt_total     (out_ch.volt_total),
  .balance_mask   (out_ch.balance_mask),
  .balance_enable (out_ch.balance_enable),
  .jump_flag      (out_ch.jump_flag)
);

`default_nettype wire
